FILE: rtl/hamming_packet_encoder_defines.svh
// Assertion macros shared by the Hamming packet encoder modules.
`ifndef HAMMING_PACKET_ENCODER_DEFINES_SVH
`define HAMMING_PACKET_ENCODER_DEFINES_SVH

// Checked only outside reset.
`define HPE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hpe assertion failed");

// Checked on every edge, reset included.
`define HPE_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hpe assertion failed");

`endif

FILE: rtl/hpe_pkg.sv
// Package: constants, types and helper functions of the Hamming packet encoder.
package hpe_pkg;

  localparam int MAX_CHECK_BITS = 8;
  localparam int MIN_CHECK_BITS = 4;
  localparam int R_W            = 4;
  localparam int BYTE_W         = 8;
  localparam int BIT_W          = 3;
  localparam int WIN_AW         = BIT_W + 1;

  localparam int PKT_BYTES  = 1 << (MAX_CHECK_BITS - MIN_CHECK_BITS);
  localparam int PKT_AW     = $clog2(PKT_BYTES);
  localparam int CNT_W      = $clog2(PKT_BYTES + 1);
  localparam int DIDX_W     = PKT_AW + BIT_W;

  localparam int CODE_BITS  = (1 << (MAX_CHECK_BITS - 1)) + MAX_CHECK_BITS;
  localparam int CODE_BYTES = (CODE_BITS + 7) >> 3;
  localparam int IDX_W      = $clog2(CODE_BYTES);
  localparam int POS_W      = $clog2(CODE_BITS + 1);
  localparam int LG_W       = $clog2(POS_W);

  localparam int BANKS      = 2;
  localparam int BANK_W     = $clog2(BANKS);
  localparam int QC_W       = $clog2(BANKS + 1);
  localparam int MEM_AW     = BANK_W + PKT_AW;

  localparam int OFIFO_DEPTH = 4;
  localparam int OF_AW       = $clog2(OFIFO_DEPTH);
  localparam int OF_CW       = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0] nbytes_in;
    logic [POS_W-1:0] syn;
    logic [R_W-1:0]   r;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [BANK_W-1:0] wr_slot;
    logic [BANK_W-1:0] rd_slot;
  } qstat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              packet_last;
    logic              message_last;
  } out_t;

  // 1-based codeword position of data bit d (skips positions 1, 2, 4, ...)
  function automatic logic [POS_W-1:0] data_pos(input logic [DIDX_W-1:0] d);
    logic [POS_W-1:0] q;
    q = POS_W'(d) + POS_W'(3);
    for (int k = 2; k < MAX_CHECK_BITS; k++) begin
      if (q >= POS_W'(1 << k)) q = q + POS_W'(1);
    end
    return q;
  endfunction

  function automatic logic [LG_W-1:0] floor_log2(input logic [POS_W-1:0] v);
    logic [LG_W-1:0] lg;
    lg = '0;
    for (int k = 0; k < POS_W; k++) begin
      if (v[k]) lg = LG_W'(k);
    end
    return lg;
  endfunction

endpackage

FILE: rtl/hpe_front.sv
// Front end: collects message bytes into a packet bank and accumulates its syndrome.
module hpe_front
  import hpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              message_end,
  output logic              full,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [R_W-1:0]    cfg_data,
  input  qstat_t            qstat,
  output logic              q_push,
  output cmd_t              q_cmd,
  output wr_req_t           mem_wr
);

  logic [R_W-1:0]   check_bits;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] syn;

  logic [R_W-1:0]   r_eff;
  logic [CNT_W-1:0] pkt_bytes;
  logic [CNT_W-1:0] count_next;
  logic [POS_W-1:0] syn_next;
  logic             accept;
  logic             done;

  always_comb begin
    if (check_bits < R_W'(MIN_CHECK_BITS)) begin
      r_eff = R_W'(MIN_CHECK_BITS);
    end else if (check_bits > R_W'(MAX_CHECK_BITS)) begin
      r_eff = R_W'(MAX_CHECK_BITS);
    end else begin
      r_eff = check_bits;
    end
  end

  assign pkt_bytes  = CNT_W'(1) << (r_eff - R_W'(MIN_CHECK_BITS));
  assign full       = qstat.full;
  assign cfg_ready  = 1'b1;
  assign accept     = push && !qstat.full;
  assign count_next = count + CNT_W'(1);
  assign done       = accept && ((count_next == pkt_bytes) || message_end);

  always_comb begin
    syn_next = syn;
    for (int b = 0; b < BYTE_W; b++) begin
      if (data_byte[b]) syn_next = syn_next ^ data_pos({count[PKT_AW-1:0], BIT_W'(b)});
    end
  end

  assign q_push = done;
  assign q_cmd  = '{nbytes_in: count_next, syn: syn_next, r: r_eff, last: message_end};
  assign mem_wr = '{en: accept, addr: {qstat.wr_slot, count[PKT_AW-1:0]}, data: data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      check_bits <= R_W'(MIN_CHECK_BITS);
      count      <= '0;
      syn        <= '0;
    end else if (cfg_valid) begin
      check_bits <= cfg_data;
      count      <= '0;
      syn        <= '0;
    end else if (accept) begin
      if (done) begin
        count <= '0;
        syn   <= '0;
      end else begin
        count <= count_next;
        syn   <= syn_next;
      end
    end
  end

endmodule

FILE: rtl/hpe_cmd_queue.sv
// Packet request queue between front and back end; slot index doubles as packet bank.
`include "hamming_packet_encoder_defines.svh"
module hpe_cmd_queue
  import hpe_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t qstat
);

  cmd_t              slots [BANKS];
  logic [BANK_W-1:0] wr_ptr;
  logic [BANK_W-1:0] rd_ptr;
  logic [QC_W-1:0]   cnt;

  logic full;
  logic empty;

  assign full  = (cnt == QC_W'(BANKS));
  assign empty = (cnt == '0);
  assign head  = slots[rd_ptr];
  assign qstat = '{full: full, empty: empty, wr_slot: wr_ptr, rd_slot: rd_ptr};

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + BANK_W'(1);
      if (pop)  rd_ptr <= rd_ptr + BANK_W'(1);
      cnt <= cnt + QC_W'(push) - QC_W'(pop);
    end
  end

  `HPE_ASSERT(a_push_has_room, push |-> !full)
  `HPE_ASSERT(a_pop_has_entry, pop |-> !empty)

endmodule

FILE: rtl/hpe_back.sv
// Back end: packet memory, codeword byte generation and result queue.
`include "hamming_packet_encoder_defines.svh"
module hpe_back
  import hpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  wr_req_t           mem_wr,
  input  qstat_t            qstat,
  input  cmd_t              head,
  output logic              q_pop,
  output logic [BYTE_W-1:0] code_byte,
  output logic              packet_last,
  output logic              message_last,
  output logic              empty,
  input  logic              pop
);

  logic [BYTE_W-1:0] pkt_mem [BANKS * PKT_BYTES];
  logic [BYTE_W-1:0] rd_lo;
  logic [BYTE_W-1:0] rd_hi;

  logic [IDX_W-1:0]  byte_idx;
  logic [POS_W-1:0]  nbits;
  logic [IDX_W-1:0]  last_idx;
  logic [PKT_AW-1:0] lo;
  logic [CNT_W-1:0]  hi;
  logic              issue;

  logic              sb_valid;
  logic [IDX_W-1:0]  sb_idx;
  logic [PKT_AW-1:0] sb_lo;
  logic              sb_lo_ok;
  logic              sb_hi_ok;
  logic [POS_W-1:0]  sb_syn;
  logic [POS_W-1:0]  sb_nbits;
  logic              sb_plast;
  logic              sb_mlast;
  logic [BYTE_W-1:0] code_next;

  out_t             ofifo [OFIFO_DEPTH];
  logic [OF_AW-1:0] of_wp;
  logic [OF_AW-1:0] of_rp;
  logic [OF_CW-1:0] of_cnt;
  logic             of_pop;

  // stage A: pick the two packet bytes that cover this code byte
  assign nbits    = (POS_W'(1) << (head.r - R_W'(1))) + POS_W'(head.r);
  assign last_idx = IDX_W'((nbits - POS_W'(1)) >> 3);
  assign lo       = (byte_idx == '0) ? '0 : PKT_AW'(byte_idx - IDX_W'(1));
  assign hi       = CNT_W'(lo) + CNT_W'(1);
  assign issue    = !qstat.empty && ((of_cnt + OF_CW'(sb_valid)) < OF_CW'(OFIFO_DEPTH));
  assign q_pop    = issue && (byte_idx == last_idx);

  always_ff @(posedge clk) begin
    if (mem_wr.en) pkt_mem[mem_wr.addr] <= mem_wr.data;
    if (issue) begin
      rd_lo <= pkt_mem[{qstat.rd_slot, lo}];
      rd_hi <= pkt_mem[{qstat.rd_slot, hi[PKT_AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sb_idx   <= byte_idx;
      sb_lo    <= lo;
      sb_lo_ok <= CNT_W'(lo) < head.nbytes_in;
      sb_hi_ok <= hi < head.nbytes_in;
      sb_syn   <= head.syn;
      sb_nbits <= nbits;
      sb_plast <= q_pop;
      sb_mlast <= q_pop && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
      sb_valid <= 1'b0;
    end else begin
      sb_valid <= issue;
      if (issue) byte_idx <= q_pop ? '0 : byte_idx + IDX_W'(1);
    end
  end

  // stage B: parity, data or zero fill for each of the eight positions
  always_comb begin
    logic [POS_W-1:0]      q;
    logic [POS_W-1:0]      d;
    logic [POS_W-1:0]      off;
    logic [LG_W-1:0]       lg;
    logic [2*BYTE_W-1:0]   win;
    win = {sb_hi_ok ? rd_hi : '0, sb_lo_ok ? rd_lo : '0};
    code_next = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      q   = POS_W'({sb_idx, BIT_W'(b)}) + POS_W'(1);
      lg  = floor_log2(q);
      d   = q - POS_W'(2) - POS_W'(lg);
      off = d - POS_W'({sb_lo, BIT_W'(0)});
      if (q > sb_nbits) begin
        code_next[b] = 1'b0;
      end else if ((q & (q - POS_W'(1))) == '0) begin
        code_next[b] = sb_syn[lg];
      end else begin
        code_next[b] = win[off[WIN_AW-1:0]];
      end
    end
  end

  // result queue
  assign empty        = (of_cnt == '0);
  assign of_pop       = pop && !empty;
  assign code_byte    = ofifo[of_rp].code_byte;
  assign packet_last  = ofifo[of_rp].packet_last;
  assign message_last = ofifo[of_rp].message_last;

  always_ff @(posedge clk) begin
    if (sb_valid) begin
      ofifo[of_wp] <= '{code_byte: code_next, packet_last: sb_plast, message_last: sb_mlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      of_wp  <= '0;
      of_rp  <= '0;
      of_cnt <= '0;
    end else begin
      if (sb_valid) of_wp <= of_wp + OF_AW'(1);
      if (of_pop)   of_rp <= of_rp + OF_AW'(1);
      of_cnt <= of_cnt + OF_CW'(sb_valid) - OF_CW'(of_pop);
    end
  end

  `HPE_ASSERT(a_ofifo_no_overflow, sb_valid |-> (of_cnt != OF_CW'(OFIFO_DEPTH)))
  `HPE_ASSERT(a_msg_last_ends_packet, !empty |-> (!message_last || packet_last))
  `HPE_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> empty)

endmodule

FILE: rtl/hamming_packet_encoder.sv
// Top level of the Hamming packet encoder: front end, request queue, back end.
// Path: a packet's first code byte passes the request queue, stage A registers and result queue before pop.
// Throughput: 1 byte in per cycle into a free bank; 1 code byte out per cycle while pop is held.
// Sustained rate: set by the single output port; ceil(n/8) code bytes per 2^(r-4) data bytes.
// Reset: synchronous; clears queues and counters, check_bits returns to 4.
module hamming_packet_encoder
  import hpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              message_end,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] code_byte,
  output logic              packet_last,
  output logic              message_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [R_W-1:0]    cfg_data
);

  qstat_t  qstat;
  cmd_t    q_cmd;
  cmd_t    head;
  wr_req_t mem_wr;
  logic    q_push;
  logic    q_pop;

  hpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .message_end (message_end),
    .full        (full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .qstat       (qstat),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .mem_wr      (mem_wr)
  );

  hpe_cmd_queue u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (head),
    .qstat    (qstat)
  );

  hpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mem_wr       (mem_wr),
    .qstat        (qstat),
    .head         (head),
    .q_pop        (q_pop),
    .code_byte    (code_byte),
    .packet_last  (packet_last),
    .message_last (message_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
